// ===== design/cul_pkg.sv =====
// cul_pkg: shared types and constants for the combination unranking block
// field widths, status codes, sequencer states and adder unit types
// no dependencies
`default_nettype none

package cul_pkg;

    localparam int RANK_W = 30;
    localparam int SIZE_W = 6;
    localparam int ELEM_W = 5;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_VALID   = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    typedef enum logic [2:0] {
        S_FILL,
        S_FLUSH,
        S_IDLE,
        S_CHECK,
        S_WALK
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [RANK_W-1:0] value;
        logic              borrow;
    } alu_res_t;

endpackage

`default_nettype wire

// ===== design/combination_unrank_lex_top.sv =====
// combination_unrank_lex_top: lexicographic unranking of k-subsets
// after reset a fill sweep builds pascal's triangle in ram, then a flush state follows;
// no item is taken meanwhile; reset clears the sequencer, the fill counters and the output valid flag
// an accepted item goes through a check state, then a walk over the positions up to the last chosen
// one (n at most); k=0, k>n or n>N_MAX: result loaded at accept, rank too large: after check
// a new item is taken only once the last one is through; a stalled result holds the walk
`default_nettype none

module combination_unrank_lex_top
    import cul_pkg::*;
#(
    parameter int N_MAX = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [RANK_W-1:0] rank_index,
    input  wire logic [SIZE_W-1:0] choose_count,
    input  wire logic [SIZE_W-1:0] set_size,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [ELEM_W-1:0] element,
    output logic                   last,
    output logic      [STAT_W-1:0] status
);

    localparam int AW     = $clog2(N_MAX + 1);
    localparam int ADDR_W = 2 * AW;
    localparam int DEPTH  = 2 ** ADDR_W;

    state_t state_reg, state_next;

    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [SIZE_W-1:0] n_reg, n_next;
    logic [SIZE_W-1:0] remk_reg, remk_next;
    logic [ELEM_W-1:0] pos_reg, pos_next;

    logic [AW-1:0] fa_reg, fa_next;
    logic [AW-1:0] fb_reg, fb_next;
    logic          wr_valid_reg;
    logic [AW-1:0] wa_reg, wb_reg;

    logic              out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0] element_reg, element_next;
    logic              last_reg, last_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic              in_accept;
    logic              out_free;
    logic              req_bad;
    logic              fill_done;
    logic              load;
    logic [RANK_W-1:0] rd_a, rd_b;
    logic [RANK_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_a, raddr_b;
    logic [SIZE_W-1:0] walk_a, walk_b;
    alu_op_t           alu_op;
    alu_res_t          alu_res;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;
    assign req_bad   = (set_size > SIZE_W'(N_MAX)) || (choose_count > set_size);
    assign fill_done = (fa_reg == AW'(N_MAX)) && (fb_reg == AW'(N_MAX));

    // shared unit: pascal sums during fill, rank compare-subtract otherwise
    assign alu_op = wr_valid_reg ? ALU_ADD : ALU_SUB;

    cul_alu u_alu (
        .op  (alu_op),
        .opa (wr_valid_reg ? rd_b : rank_reg),
        .opb (rd_a),
        .res (alu_res)
    );

    always_comb
    begin
        if (wa_reg == '0)
        begin
            wdata = (wb_reg == '0) ? RANK_W'(1) : '0;
        end
        else if (wb_reg == '0)
        begin
            wdata = RANK_W'(1);
        end
        else
        begin
            wdata = alu_res.value;
        end
    end

    // table address is {a, b}; reads follow the next position so data lines up
    assign walk_a = n_next - {1'b0, pos_next} - SIZE_W'(1);
    assign walk_b = remk_next - SIZE_W'(1);

    always_comb
    begin
        if (state_reg == S_FILL)
        begin
            raddr_a = {AW'(fa_reg - 1'b1), AW'(fb_reg - 1'b1)};
        end
        else if (state_next == S_CHECK)
        begin
            raddr_a = {AW'(n_next), AW'(remk_next)};
        end
        else
        begin
            raddr_a = {AW'(walk_a), AW'(walk_b)};
        end
    end

    assign raddr_b = {AW'(fa_reg - 1'b1), fb_reg};

    cul_ram #(
        .WIDTH (RANK_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (wr_valid_reg),
        .waddr   ({wa_reg, wb_reg}),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rd_a),
        .raddr_b (raddr_b),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_FILL:
            begin
                if (fill_done)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_accept && (choose_count != '0) && !req_bad)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (alu_res.borrow)
                begin
                    state_next = S_WALK;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (alu_res.borrow && out_free && (remk_reg == SIZE_W'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rank_next    = rank_reg;
        n_next       = n_reg;
        remk_next    = remk_reg;
        pos_next     = pos_reg;
        fa_next      = fa_reg;
        fb_next      = fb_reg;
        load         = 1'b0;
        element_next = '0;
        last_next    = 1'b1;
        status_next  = ST_VALID;
        case (state_reg)
            S_FILL:
            begin
                if (fb_reg == AW'(N_MAX))
                begin
                    fb_next = '0;
                    fa_next = fa_reg + 1'b1;
                end
                else
                begin
                    fb_next = fb_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    rank_next = rank_index;
                    n_next    = set_size;
                    remk_next = choose_count;
                    if (choose_count == '0)
                    begin
                        load        = 1'b1;
                        status_next = ST_EMPTY;
                    end
                    else if (req_bad)
                    begin
                        load        = 1'b1;
                        status_next = ST_INVALID;
                    end
                end
            end
            S_CHECK:
            begin
                if (alu_res.borrow)
                begin
                    pos_next = '0;
                end
                else if (out_free)
                begin
                    load        = 1'b1;
                    status_next = ST_INVALID;
                end
            end
            S_WALK:
            begin
                if (alu_res.borrow)
                begin
                    if (out_free)
                    begin
                        load         = 1'b1;
                        element_next = pos_reg;
                        last_next    = (remk_reg == SIZE_W'(1));
                        remk_next    = remk_reg - SIZE_W'(1);
                        pos_next     = pos_reg + 1'b1;
                    end
                end
                else
                begin
                    rank_next = alu_res.value;
                    pos_next  = pos_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            fa_reg        <= '0;
            fb_reg        <= '0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fa_reg        <= fa_next;
            fb_reg        <= fb_next;
            wr_valid_reg  <= (state_reg == S_FILL);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
        n_reg    <= n_next;
        remk_reg <= remk_next;
        pos_reg  <= pos_next;
        wa_reg   <= fa_reg;
        wb_reg   <= fb_reg;
        if (load)
        begin
            element_reg <= element_next;
            last_reg    <= last_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign element   = element_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_VALID)) |-> (last_reg && (element_reg == '0)))
        else $error("empty or invalid item not a single zero result");

    a_walk_remk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (remk_reg != '0))
        else $error("walk running with nothing left to choose");

    a_walk_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> ({1'b0, pos_reg} < n_reg))
        else $error("walk ran past the ground set");

    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WALK) && (state_next == S_IDLE)) |=> (out_valid_reg && last_reg))
        else $error("walk ended without a last result");

endmodule

`default_nettype wire

// ===== design/cul_ram.sv =====
// cul_ram: generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module cul_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== design/cul_alu.sv =====
// cul_alu: shared add / subtract unit with borrow out
// depends on cul_pkg
`default_nettype none

module cul_alu
    import cul_pkg::*;
(
    input  wire alu_op_t           op,
    input  wire logic [RANK_W-1:0] opa,
    input  wire logic [RANK_W-1:0] opb,
    output alu_res_t               res
);

    logic [RANK_W:0] sum_ext;

    always_comb
    begin
        case (op)
            ALU_ADD: sum_ext = {1'b0, opa} + {1'b0, opb};
            ALU_SUB: sum_ext = {1'b0, opa} - {1'b0, opb};
            default: sum_ext = '0;
        endcase
        res.value  = sum_ext[RANK_W-1:0];
        res.borrow = sum_ext[RANK_W];
    end

endmodule

`default_nettype wire

// ===== tb/sv/unrank_checker.sv =====
// unrank_checker: watches both channels of the unranking block, predicts each subset
// and compares every result item field by field; depends on cul_pkg only
`timescale 1ns / 1ps

module unrank_checker
    import cul_pkg::*;
#(
    parameter int N_MAX = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [RANK_W-1:0] rank_index,
    input  wire logic [SIZE_W-1:0] choose_count,
    input  wire logic [SIZE_W-1:0] set_size,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [ELEM_W-1:0] element,
    input  wire logic              last,
    input  wire logic [STAT_W-1:0] status,
    output int                     fail_count,
    output int                     pending,
    output int                     items_seen,
    output int                     results_seen,
    output int                     rejects_seen
);

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
        logic [STAT_W-1:0] status;
    } subset_elem_t;

    subset_elem_t subset_q[$];

    function automatic longint unsigned choose_of(input int a, input int b);
        longint unsigned v;
        int i;
        v = 1;
        if (b > a)
        begin
            return 0;
        end
        if (b > a - b)
        begin
            b = a - b;
        end
        for (i = 1; i <= b; i++)
        begin
            v = v * longint'(a - b + i) / longint'(i);
        end
        return v;
    endfunction

    function automatic void queue_result(input logic [ELEM_W-1:0] elem, input logic fin,
                                         input logic [STAT_W-1:0] stat);
        subset_elem_t r;
        r.element = elem;
        r.last    = fin;
        r.status  = stat;
        subset_q.insert(subset_q.size(), r);
    endfunction

    function automatic void unrank_subset(input logic [RANK_W-1:0] m,
                                          input logic [SIZE_W-1:0] k,
                                          input logic [SIZE_W-1:0] n);
        longint unsigned rest;
        longint unsigned c;
        int left;
        int pos;
        int nn;
        int kk;
        rest = 64'(m);
        nn   = int'(n);
        kk   = int'(k);
        left = kk;
        if (kk == 0)
        begin
            queue_result('0, 1'b1, ST_EMPTY);
            return;
        end
        if (nn > N_MAX || kk > nn || rest >= choose_of(nn, kk))
        begin
            queue_result('0, 1'b1, ST_INVALID);
            return;
        end
        for (pos = 0; pos < nn && left > 0; pos++)
        begin
            c = choose_of(nn - pos - 1, left - 1);
            if (rest < c)
            begin
                left--;
                queue_result(ELEM_W'(pos), (left == 0), ST_VALID);
            end
            else
            begin
                rest -= c;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        subset_elem_t want;
        subset_elem_t got;
        if (!rst_n)
        begin
            subset_q.delete();
            fail_count   <= 0;
            pending      <= 0;
            items_seen   <= 0;
            results_seen <= 0;
            rejects_seen <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                unrank_subset(rank_index, choose_count, set_size);
                items_seen <= items_seen + 1;
            end
            if (out_valid && !out_stall)
            begin
                got = '{element: element, last: last, status: status};
                results_seen <= results_seen + 1;
                if (status != ST_VALID)
                begin
                    rejects_seen <= rejects_seen + 1;
                end
                if (subset_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("%0t: unexpected item element=%0d last=%0b status=%0d",
                                 $time, element, last, status);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = subset_q.pop_front();
                    if (want != got)
                    begin
                        if (fail_count < 10)
                        begin
                            $display({"%0t: mismatch expected element=%0d last=%0b status=%0d,",
                                      " got element=%0d last=%0b status=%0d"},
                                     $time, want.element, want.last, want.status,
                                     got.element, got.last, got.status);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= subset_q.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: top of the combination unranking testbench, drives directed and random
// requests with random idling and gives the verdict; depends on cul_pkg, combination_unrank_lex_top and unrank_checker
`timescale 1ns / 1ps

module testbench
    import cul_pkg::*;
();

    localparam int N_MAX          = 32;
    localparam int RANDOM_ITEMS   = 392;
    localparam int CALM_ITEMS     = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 48;
    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [RANK_W-1:0] rank_index;
    logic [SIZE_W-1:0] choose_count;
    logic [SIZE_W-1:0] set_size;
    logic              out_valid;
    logic              out_stall;
    logic [ELEM_W-1:0] element;
    logic              last;
    logic [STAT_W-1:0] status;

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;
    int rejects_seen;
    int quiet_cycles = 0;
    int gap_pct      = 0;
    logic calm       = 1'b0;

    longint unsigned pascal [0:N_MAX][0:N_MAX];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    combination_unrank_lex_top #(
        .N_MAX(N_MAX)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rank_index  (rank_index),
        .choose_count(choose_count),
        .set_size    (set_size),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .element     (element),
        .last        (last),
        .status      (status)
    );

    unrank_checker #(
        .N_MAX(N_MAX)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rank_index  (rank_index),
        .choose_count(choose_count),
        .set_size    (set_size),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .element     (element),
        .last        (last),
        .status      (status),
        .fail_count  (fail_count),
        .pending     (pending),
        .items_seen  (items_seen),
        .results_seen(results_seen),
        .rejects_seen(rejects_seen)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("combination_unrank_lex_top test failed");
                $finish;
            end
        end
    end

    // receiver idling: stall bursts and free runs, none once calm
    initial
    begin : rx_idle
        int run;
        logic stalling;
        run = 0;
        stalling = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run == 0)
            begin
                stalling = ($urandom_range(0, 2) == 0);
                run = $urandom_range(1, 18);
                if (!stalling && $urandom_range(0, 4) == 0)
                begin
                    run = 80;
                end
            end
            out_stall <= stalling && !calm;
            run--;
        end
    end

    task automatic send_request(input logic [RANK_W-1:0] m, input int k, input int n);
        int gap;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        rank_index   <= m;
        choose_count <= SIZE_W'(k);
        set_size     <= SIZE_W'(n);
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int i;
        int j;
        int n;
        int k;
        int kind;
        longint unsigned c;
        logic [RANK_W-1:0] m;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rank_index   = '0;
        choose_count = '0;
        set_size     = '0;

        for (i = 0; i <= N_MAX; i++)
        begin
            for (j = 0; j <= N_MAX; j++)
            begin
                pascal[i][j] = (j == 0) ? 1 : (i == 0) ? 0 : pascal[i-1][j-1] + pascal[i-1][j];
            end
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty selections, full selection, bounds of rank, k and n
        send_request('0, 0, 0);
        send_request(RANK_MAX, 0, 63);
        send_request('0, 32, 32);
        send_request(RANK_W'(1), 32, 32);
        send_request(RANK_W'(pascal[32][16] - 1), 16, 32);
        send_request(RANK_W'(pascal[32][16]), 16, 32);
        send_request(RANK_MAX, 16, 32);
        send_request(RANK_W'(31), 1, 32);
        send_request('0, 1, 32);
        send_request('0, 1, 1);
        send_request(RANK_W'(1), 1, 2);
        send_request('0, 1, 0);
        send_request('0, 63, 5);
        send_request('0, 1, 63);
        send_request('0, 33, 33);
        send_request(RANK_W'(31), 31, 32);
        send_request('0, 3, 10);
        send_request(RANK_W'(119), 3, 10);
        send_request(RANK_W'(495), 2, 32);
        send_request(RANK_W'(pascal[20][10] - 1), 10, 20);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                gap_pct = $urandom_range(0, 3) * 25;
            end
            calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
                k = $urandom_range(1, n);
                c = pascal[n][k];
                m = RANK_W'($urandom_range(0, 32'(c - 1)));
            end
            else if (kind < 80)
            begin
                n = $urandom_range(0, 63);
                k = 0;
                m = RANK_W'($urandom);
            end
            else if (kind < 85)
            begin
                n = $urandom_range(0, 31);
                k = $urandom_range(n + 1, 63);
                m = RANK_W'($urandom);
            end
            else if (kind < 90)
            begin
                n = $urandom_range(1, 32);
                k = $urandom_range(1, n);
                c = pascal[n][k];
                if ($urandom_range(0, 1) == 0)
                begin
                    m = RANK_W'(c);
                end
                else
                begin
                    m = RANK_W'(c + $urandom_range(0, 32'(RANK_MAX - c)));
                end
            end
            else if (kind < 94)
            begin
                n = $urandom_range(33, 63);
                k = $urandom_range(1, n);
                m = RANK_W'($urandom_range(0, 3));
            end
            else
            begin
                n = $urandom_range(0, 63);
                k = $urandom_range(0, 63);
                m = RANK_W'($urandom);
            end
            send_request(m, k, n);
        end
        in_valid <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests and %0d result items, %0d of them empty or rejected",
                 items_seen, results_seen, rejects_seen);
        $display("mismatches or stray items: %0d", fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("combination_unrank_lex_top test passed");
        end
        else
        begin
            $display("combination_unrank_lex_top test failed");
        end
        $finish;
    end

endmodule
